>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the knee curve block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/mkc_pkg.sv
// Types, constants and sequencer states of the multi-knee compressor curve
package mkc_pkg;
	localparam int MAX_KNEES_DEF = 4;
	localparam int ACC_W = 52;
	localparam int MUL_W = 18;
	localparam int PROD_W = 2 * MUL_W;
	localparam int NUM_W = 50;
	localparam int DIVN_W = 51;
	localparam int DIVD_W = 18;
	localparam int QUO_W = 32;

	localparam logic ACTION_LEVEL = 1'b0;
	localparam logic ACTION_WRITE = 1'b1;

	localparam logic [15:0] UNITY_Q15 = 16'd32768;

	typedef struct packed {
		logic signed [15:0] threshold;
		logic [15:0]        ratio_inverse;
		logic [14:0]        width;
	} knee_entry_t;

	typedef struct packed {
		logic               action;
		logic [1:0]         knee_slot;
		logic signed [15:0] knee_threshold;
		logic [15:0]        knee_ratio_inverse;
		logic [14:0]        knee_width;
		logic signed [15:0] level_db;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_level_db;
		logic [2:0]         active_band;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_OFS,
		ST_DECIDE,
		ST_LINE,
		ST_K_PW,
		ST_K_PK,
		ST_K_SQ,
		ST_K_LO,
		ST_K_HI,
		ST_K_NUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} state_t;
endpackage

>>> rtl/mkc_knee_mem.sv
// Knee entry store: one write port, one registered read port
module mkc_knee_mem #(
	parameter int DEPTH = mkc_pkg::MAX_KNEES_DEF,
	parameter int IDX_W = 2
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  mkc_pkg::knee_entry_t wr_data,
	input  logic [IDX_W-1:0]     rd_addr,
	output mkc_pkg::knee_entry_t rd_data
);
	mkc_pkg::knee_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule

>>> rtl/mkc_mul.sv
// Shared signed multiplier with a registered product
module mkc_mul #(
	parameter int W = mkc_pkg::MUL_W
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

>>> rtl/mkc_div.sv
// Restoring divider, one quotient bit a cycle
module mkc_div #(
	parameter int N_W = mkc_pkg::DIVN_W,
	parameter int D_W = mkc_pkg::DIVD_W,
	parameter int Q_W = mkc_pkg::QUO_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic           done,
	output logic [Q_W-1:0] quotient
);
	localparam int CNT_W = $clog2(Q_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   div_q;
	logic [Q_W-1:0]   quo_q;
	logic [D_W:0]     trial;
	logic             ge;

	assign trial = {rem_q, quo_q[Q_W-1]};
	assign ge = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Upper dividend bits sit below the divisor, so the quotient fits Q_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= D_W'(dividend[N_W-1:Q_W]);
			quo_q <= dividend[Q_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? D_W'(trial - {1'b0, div_q}) : D_W'(trial);
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;
endmodule

>>> rtl/multi_knee_compressor_curve_core.sv
// Multi-knee compressor static curve: sequencer, accumulator and output word
//
//  channel | dir | handshake            | word
//  in      | in  | in_valid / in_ready  | in_item (write or level item)
//  out     | out | out_valid / out_ready| out_item (level and active band)
//  cfg     | in  | cfg_valid / cfg_ready| cfg_data (knee_count)
//
// Write item: IDLE only. Level item: RD, CHK for each knee, and OFS where a
// started knee above the first adds its offset; then DECIDE, FIN below every
// knee, DECIDE, LINE, FIN on the ratio line, or DECIDE, K_PW to K_NUM, DIV_GO,
// DIV_WAIT (32-step divider), FIN in a soft knee; in_ready returns with the
// result word. Reset clears the sequencer, knee_count and out_valid; knee
// entries are undefined until written; FIN holds while the last word is unread.
module multi_knee_compressor_curve_core #(
	parameter int MAX_KNEES = mkc_pkg::MAX_KNEES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mkc_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output mkc_pkg::out_item_t out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_data
);
	`include "assert_macros.svh"

	localparam int IDX_W = (MAX_KNEES > 1) ? $clog2(MAX_KNEES) : 1;
	localparam int CNT_W = $clog2(MAX_KNEES + 1);
	localparam int ACC_W = mkc_pkg::ACC_W;
	localparam int MUL_W = mkc_pkg::MUL_W;
	localparam int PROD_W = mkc_pkg::PROD_W;
	localparam int NUM_W = mkc_pkg::NUM_W;
	localparam int DIVN_W = mkc_pkg::DIVN_W;
	localparam int DIVD_W = mkc_pkg::DIVD_W;
	localparam int QUO_W = mkc_pkg::QUO_W;

	mkc_pkg::state_t state_q, state_nxt;

	logic [2:0]         knee_count_q;
	logic signed [15:0] lvl_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_sel;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   idx_q;
	logic               found_q;
	logic signed [15:0] tprev_q;
	logic [15:0]        rprev_q;
	logic signed [15:0] sel_t_q;
	logic [15:0]        sel_r_q;
	logic [14:0]        sel_w_q;
	logic [15:0]        sel_p_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [31:0]        ksq_q;
	logic signed [NUM_W-1:0] num_q;
	logic               neg_q;
	logic               out_valid_q;
	mkc_pkg::out_item_t out_item_q;

	mkc_pkg::knee_entry_t wr_entry, rd_entry;
	logic wr_en;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	logic              div_start, div_busy, div_done;
	logic [DIVN_W-1:0] div_n;
	logic [DIVD_W-1:0] div_d;
	logic [QUO_W-1:0]  div_q;

	logic accept, level_acc, last, first, started, above, out_free;
	logic signed [17:0] lvl2, rd_t2, rd_w, sel_t2, sel_w, knee_lo, knee_hi, k2;
	logic [15:0]        k2u;
	logic signed [17:0] rp;
	logic signed [ACC_W-1:0] t_term, lvl_term, prod2_term, quo_term;
	logic signed [ACC_W-1:0] n_full, m_full, rnd;
	logic signed [35:0] res_full;
	logic signed [15:0] res_sat;
	logic signed [QUO_W:0] quo_s;

	// Entry store, multiplier and divider
	mkc_knee_mem #(
		.DEPTH(MAX_KNEES),
		.IDX_W(IDX_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(IDX_W'(in_item.knee_slot)),
		.wr_data(wr_entry),
		.rd_addr(i_q),
		.rd_data(rd_entry)
	);

	mkc_mul #(
		.W(MUL_W)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	mkc_div #(
		.N_W(DIVN_W),
		.D_W(DIVD_W),
		.Q_W(QUO_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_n),
		.divisor (div_d),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_q)
	);

	assign accept = in_valid && in_ready;
	assign level_acc = accept && (in_item.action == mkc_pkg::ACTION_LEVEL);
	assign wr_en = accept && (in_item.action == mkc_pkg::ACTION_WRITE)
		&& (32'(in_item.knee_slot) < MAX_KNEES);
	assign wr_entry.threshold = in_item.knee_threshold;
	assign wr_entry.ratio_inverse = in_item.knee_ratio_inverse;
	assign wr_entry.width = in_item.knee_width;

	assign cnt_sel = (32'(knee_count_q) > MAX_KNEES) ? CNT_W'(MAX_KNEES)
		: CNT_W'(knee_count_q);
	assign last = CNT_W'({1'b0, i_q} + (IDX_W + 1)'(1)) == cnt_q;
	assign first = i_q == '0;

	// Knee edges compared at twice the level, so half a width stays exact
	assign lvl2 = {lvl_q[15], lvl_q, 1'b0};
	assign rd_t2 = {rd_entry.threshold[15], rd_entry.threshold, 1'b0};
	assign rd_w = {3'b000, rd_entry.width};
	assign knee_lo = rd_t2 - rd_w;
	assign started = lvl2 > knee_lo;
	assign sel_t2 = {sel_t_q[15], sel_t_q, 1'b0};
	assign sel_w = {3'b000, sel_w_q};
	assign knee_hi = sel_t2 + sel_w;
	assign above = lvl2 >= knee_hi;
	assign k2 = lvl2 - sel_t2 + sel_w;
	assign k2u = k2[15:0];
	assign rp = {2'b00, sel_r_q} - {2'b00, sel_p_q};

	assign t_term = {{(ACC_W - 32){sel_t_q[15]}}, sel_t_q, 16'h0000};
	assign lvl_term = {{(ACC_W - 32){lvl_q[15]}}, lvl_q, 16'h0000};
	assign prod2_term = {{(ACC_W - PROD_W - 1){prod[PROD_W-1]}}, prod, 1'b0};
	assign quo_s = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
	assign quo_term = {{(ACC_W - QUO_W - 1){quo_s[QUO_W]}}, quo_s};

	// Rounded knee term: floor((2*num + 4w) / 8w), divided on magnitudes
	assign n_full = {{(ACC_W - NUM_W - 1){num_q[NUM_W-1]}}, num_q, 1'b0}
		+ {{(ACC_W - 17){1'b0}}, sel_w_q, 2'b00};
	assign div_d = {sel_w_q, 3'b000};
	assign m_full = n_full[ACC_W-1]
		? (-n_full + {{(ACC_W - DIVD_W){1'b0}}, div_d} - ACC_W'(1)) : n_full;
	assign div_n = m_full[DIVN_W-1:0];

	assign rnd = acc_q + ACC_W'(32768);
	assign res_full = rnd[ACC_W-1:16];
	always_comb begin
		priority if (res_full > 36'sd32767) begin
			res_sat = 16'sh7fff;
		end else if (res_full < -36'sd32768) begin
			res_sat = 16'sh8000;
		end else begin
			res_sat = res_full[15:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mkc_pkg::ST_IDLE: begin
				if (level_acc) begin
					state_nxt = (cnt_sel == '0) ? mkc_pkg::ST_DECIDE : mkc_pkg::ST_RD;
				end
			end
			mkc_pkg::ST_RD: state_nxt = mkc_pkg::ST_CHK;
			mkc_pkg::ST_CHK: begin
				priority if (started && !first) begin
					state_nxt = mkc_pkg::ST_OFS;
				end else if (last) begin
					state_nxt = mkc_pkg::ST_DECIDE;
				end else begin
					state_nxt = mkc_pkg::ST_RD;
				end
			end
			mkc_pkg::ST_OFS: state_nxt = last ? mkc_pkg::ST_DECIDE : mkc_pkg::ST_RD;
			mkc_pkg::ST_DECIDE: begin
				priority if (!found_q) begin
					state_nxt = mkc_pkg::ST_FIN;
				end else if (above) begin
					state_nxt = mkc_pkg::ST_LINE;
				end else begin
					state_nxt = mkc_pkg::ST_K_PW;
				end
			end
			mkc_pkg::ST_LINE: state_nxt = mkc_pkg::ST_FIN;
			mkc_pkg::ST_K_PW: state_nxt = mkc_pkg::ST_K_PK;
			mkc_pkg::ST_K_PK: state_nxt = mkc_pkg::ST_K_SQ;
			mkc_pkg::ST_K_SQ: state_nxt = mkc_pkg::ST_K_LO;
			mkc_pkg::ST_K_LO: state_nxt = mkc_pkg::ST_K_HI;
			mkc_pkg::ST_K_HI: state_nxt = mkc_pkg::ST_K_NUM;
			mkc_pkg::ST_K_NUM: state_nxt = mkc_pkg::ST_DIV_GO;
			mkc_pkg::ST_DIV_GO: state_nxt = mkc_pkg::ST_DIV_WAIT;
			mkc_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_nxt = mkc_pkg::ST_FIN;
				end
			end
			mkc_pkg::ST_FIN: begin
				if (out_free) begin
					state_nxt = mkc_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mkc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands and divider start
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			mkc_pkg::ST_IDLE: in_ready = 1'b1;
			mkc_pkg::ST_CHK: begin
				mul_a = {{2{rd_entry.threshold[15]}}, rd_entry.threshold}
					- {{2{tprev_q[15]}}, tprev_q};
				mul_b = {2'b00, rprev_q} - {2'b00, mkc_pkg::UNITY_Q15};
			end
			mkc_pkg::ST_DECIDE: begin
				if (above) begin
					mul_a = {{2{lvl_q[15]}}, lvl_q} - {{2{sel_t_q[15]}}, sel_t_q};
					mul_b = {2'b00, sel_r_q};
				end else begin
					mul_a = {2'b00, sel_p_q};
					mul_b = {3'b000, sel_w_q};
				end
			end
			mkc_pkg::ST_K_PW: begin
				mul_a = {2'b00, sel_p_q};
				mul_b = {2'b00, k2u};
			end
			mkc_pkg::ST_K_PK: begin
				mul_a = {2'b00, k2u};
				mul_b = {2'b00, k2u};
			end
			mkc_pkg::ST_K_LO: begin
				mul_a = rp;
				mul_b = {2'b00, ksq_q[15:0]};
			end
			mkc_pkg::ST_K_HI: begin
				mul_a = rp;
				mul_b = {2'b00, ksq_q[31:16]};
			end
			mkc_pkg::ST_DIV_GO: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mkc_pkg::ST_IDLE;
			knee_count_q <= '0;
			out_valid_q <= 1'b0;
			found_q <= 1'b0;
			i_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				knee_count_q <= cfg_data;
			end
			if (state_q == mkc_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mkc_pkg::ST_IDLE: begin
					if (level_acc) begin
						cnt_q <= cnt_sel;
						i_q <= '0;
						found_q <= 1'b0;
					end
				end
				mkc_pkg::ST_CHK: begin
					if (started) begin
						found_q <= 1'b1;
					end
					if (!(started && !first) && !last) begin
						i_q <= i_q + 1'b1;
					end
				end
				mkc_pkg::ST_OFS: begin
					if (!last) begin
						i_q <= i_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath words, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			mkc_pkg::ST_IDLE: begin
				lvl_q <= in_item.level_db;
				acc_q <= '0;
			end
			mkc_pkg::ST_CHK: begin
				tprev_q <= rd_entry.threshold;
				rprev_q <= rd_entry.ratio_inverse;
				if (started) begin
					idx_q <= i_q;
					sel_t_q <= rd_entry.threshold;
					sel_r_q <= rd_entry.ratio_inverse;
					sel_w_q <= rd_entry.width;
					sel_p_q <= first ? mkc_pkg::UNITY_Q15 : rprev_q;
				end
			end
			// Offset gathered by a started knee above the first
			mkc_pkg::ST_OFS: acc_q <= acc_q + prod2_term;
			mkc_pkg::ST_DECIDE: begin
				if (!found_q) begin
					acc_q <= acc_q + lvl_term;
				end
			end
			mkc_pkg::ST_LINE: acc_q <= acc_q + t_term + prod2_term;
			mkc_pkg::ST_K_PW: acc_q <= acc_q + t_term
				- {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
			mkc_pkg::ST_K_PK: acc_q <= acc_q
				+ {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
			mkc_pkg::ST_K_SQ: ksq_q <= prod[31:0];
			mkc_pkg::ST_K_HI: num_q <= {{(NUM_W - PROD_W){prod[PROD_W-1]}}, prod};
			mkc_pkg::ST_K_NUM: num_q <= num_q + {prod[33:0], 16'h0000};
			mkc_pkg::ST_DIV_GO: neg_q <= n_full[ACC_W-1];
			mkc_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					acc_q <= acc_q + quo_term;
				end
			end
			mkc_pkg::ST_FIN: begin
				if (out_free) begin
					out_item_q.out_level_db <= res_sat;
					out_item_q.active_band <= found_q ? 3'(idx_q) + 3'd1 : 3'd0;
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	`MKC_ASSERT_IMP(a_ready_div_idle, clk, arst_n, in_ready, !div_busy)
	`MKC_ASSERT_IMP(a_done_in_wait, clk, arst_n, div_done, state_q == mkc_pkg::ST_DIV_WAIT)
	`MKC_ASSERT_NXT(a_level_holds_in, clk, arst_n, level_acc, !in_ready)
endmodule
